// ===== src/bmt_pkg.sv =====
// shared constants, types and codes for the bounded multiset table
// no dependencies; used by the interfaces, the controller, the store and the top level
package bmt_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned IN_VAL_W = 32;
  localparam int unsigned OUT_CNT_W = 5;

  // entry address and count widths follow the capacity
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic                   ren;
    logic [IDX_W-1:0]       raddr;
    logic                   wen;
    logic [IDX_W-1:0]       waddr;
    logic [VALUE_WIDTH-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] copies;
    logic                 present;
    logic [OUT_CNT_W-1:0] occupancy;
    logic                 is_full;
    logic                 is_empty;
    logic                 rejected;
  } result_t;

endpackage

// ===== src/bmt_in_if.sv =====
// input channel of the bounded multiset table: valid/ready plus action and value
// depends on bmt_pkg
interface bmt_in_if;
  logic                          valid;
  logic                          ready;
  logic [bmt_pkg::ACTION_W-1:0]  action;
  logic [bmt_pkg::IN_VAL_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== src/bmt_out_if.sv =====
// result channel of the bounded multiset table: valid/ready plus the result fields
// depends on bmt_pkg
interface bmt_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmt_pkg::OUT_CNT_W-1:0] copies;
  logic                          present;
  logic [bmt_pkg::OUT_CNT_W-1:0] occupancy;
  logic                          is_full;
  logic                          is_empty;
  logic                          rejected;

  modport source (output valid, output copies, output present, output occupancy,
                  output is_full, output is_empty, output rejected, input ready);
  modport sink   (input valid, input copies, input present, input occupancy,
                  input is_full, input is_empty, input rejected, output ready);
endinterface

// ===== src/bmt_store.sv =====
// entry storage: one write port and one registered read port
// depends on bmt_pkg
module bmt_store (
  input  logic                            clk_i,
  input  bmt_pkg::mem_req_t               req_i,
  output logic [bmt_pkg::VALUE_WIDTH-1:0] rdata_o
);

  logic [bmt_pkg::VALUE_WIDTH-1:0] mem [bmt_pkg::CAPACITY];
  logic [bmt_pkg::VALUE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wen) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ren) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bmt_ctrl.sv =====
// sequencer: scans the entries one per cycle through a shared comparator,
// then shifts entries down on a remove that finds the value and produces the result word
// depends on bmt_pkg and bmt_in_if
module bmt_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bmt_in_if.sink                          in_i,
  input  logic [bmt_pkg::VALUE_WIDTH-1:0] rdata_i,
  output bmt_pkg::mem_req_t               req_o,
  output logic                            res_valid_o,
  input  logic                            res_take_i,
  output bmt_pkg::result_t                res_o
);

  bmt_pkg::state_e                 state_q, state_d;
  bmt_pkg::action_e                action_q, action_d;
  logic [bmt_pkg::VALUE_WIDTH-1:0] value_q, value_d;
  logic [bmt_pkg::CNT_W-1:0]       fill_q, fill_d;
  logic [bmt_pkg::CNT_W-1:0]       idx_q, idx_d;
  logic [bmt_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [bmt_pkg::IDX_W-1:0]       first_q, first_d;
  logic                            found_q, found_d;
  logic                            pv_q, pv_d;
  logic [bmt_pkg::IDX_W-1:0]       pidx_q, pidx_d;
  logic                            hit;
  logic                            more;
  logic                            full;
  logic [bmt_pkg::CNT_W-1:0]       new_fill;

  assign hit  = pv_q && (rdata_i == value_q);
  assign more = idx_q < fill_q;
  assign full = fill_q >= bmt_pkg::CNT_W'(bmt_pkg::CAPACITY);

  always_comb begin
    case (action_q)
      bmt_pkg::ACT_INSERT: new_fill = full ? fill_q : fill_q + 1'b1;
      bmt_pkg::ACT_REMOVE: new_fill = found_q ? fill_q - 1'b1 : fill_q;
      bmt_pkg::ACT_CLEAR:  new_fill = '0;
      default:             new_fill = fill_q;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    action_d = action_q;
    value_d  = value_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    first_d  = first_q;
    found_d  = found_q;
    pv_d     = 1'b0;
    pidx_d   = pidx_q;
    req_o    = '0;
    res_valid_o = 1'b0;

    res_o.copies    = bmt_pkg::OUT_CNT_W'(cnt_q);
    res_o.present   = found_q;
    res_o.occupancy = bmt_pkg::OUT_CNT_W'(new_fill);
    res_o.is_full   = new_fill >= bmt_pkg::CNT_W'(bmt_pkg::CAPACITY);
    res_o.is_empty  = new_fill == '0;
    res_o.rejected  = (action_q == bmt_pkg::ACT_INSERT) && full;

    case (state_q)
      bmt_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          action_d = bmt_pkg::action_e'(in_i.action);
          value_d  = bmt_pkg::VALUE_WIDTH'(in_i.value);
          idx_d    = '0;
          cnt_d    = '0;
          found_d  = 1'b0;
          first_d  = '0;
          state_d  = bmt_pkg::ST_SCAN;
        end
      end
      bmt_pkg::ST_SCAN: begin
        // read entry idx, compare it in the cycle after
        req_o.ren   = more;
        req_o.raddr = idx_q[bmt_pkg::IDX_W-1:0];
        pv_d        = more;
        pidx_d      = idx_q[bmt_pkg::IDX_W-1:0];
        if (more) begin
          idx_d = idx_q + 1'b1;
        end
        if (hit) begin
          cnt_d = cnt_q + 1'b1;
          if (!found_q) begin
            found_d = 1'b1;
            first_d = pidx_q;
          end
        end
        if (!more && !pv_q) begin
          if (action_q == bmt_pkg::ACT_REMOVE && found_q) begin
            idx_d   = bmt_pkg::CNT_W'(first_q) + 1'b1;
            state_d = bmt_pkg::ST_SHIFT;
          end else begin
            state_d = bmt_pkg::ST_REPLY;
          end
        end
      end
      bmt_pkg::ST_SHIFT: begin
        // move entry i+1 down to i, closing the gap left by the removed one
        req_o.ren   = more;
        req_o.raddr = idx_q[bmt_pkg::IDX_W-1:0];
        pv_d        = more;
        pidx_d      = idx_q[bmt_pkg::IDX_W-1:0];
        if (more) begin
          idx_d = idx_q + 1'b1;
        end
        if (pv_q) begin
          req_o.wen   = 1'b1;
          req_o.waddr = pidx_q - 1'b1;
          req_o.wdata = rdata_i;
        end
        if (!more && !pv_q) begin
          state_d = bmt_pkg::ST_REPLY;
        end
      end
      bmt_pkg::ST_REPLY: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          if (action_q == bmt_pkg::ACT_INSERT && !full) begin
            req_o.wen   = 1'b1;
            req_o.waddr = fill_q[bmt_pkg::IDX_W-1:0];
            req_o.wdata = value_q;
          end
          fill_d  = new_fill;
          state_d = bmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmt_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_i.ready = state_q == bmt_pkg::ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmt_pkg::ST_IDLE;
      fill_q  <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    value_q  <= value_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    first_q  <= first_d;
    found_q  <= found_d;
    pidx_q   <= pidx_d;
  end

endmodule

// ===== src/bounded_multiset_table_top.sv =====
// bounded multiset table, top level: controller, entry store and result register
// a request is accepted only from idle; the controller scans the stored entries, shifts the
//   entries behind the match down on a remove that hits, then parks the result word in the result register
// the next request is accepted only after the result word is taken; result stalls delay it
// reset: asynchronous active low, empties the table; entry contents are not cleared
// depends on bmt_pkg, bmt_in_if, bmt_out_if, bmt_store, bmt_ctrl
module bounded_multiset_table_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmt_in_if.sink    in_i,
  bmt_out_if.source out_o
);

  bmt_pkg::mem_req_t               req;
  logic [bmt_pkg::VALUE_WIDTH-1:0] rdata;
  logic                            res_valid;
  logic                            res_take;
  bmt_pkg::result_t                res;
  bmt_pkg::result_t                out_q;
  logic                            out_valid_q;

  bmt_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  bmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .rdata_i     (rdata),
    .req_o       (req),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // result register frees the controller once the word is parked here
  assign res_take = res_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.copies    = out_q.copies;
  assign out_o.present   = out_q.present;
  assign out_o.occupancy = out_q.occupancy;
  assign out_o.is_full   = out_q.is_full;
  assign out_o.is_empty  = out_q.is_empty;
  assign out_o.rejected  = out_q.rejected;

endmodule
